/* design/image_downscale_2x2_average_top_defines.svh */
`ifndef IMAGE_DOWNSCALE_2X2_AVERAGE_TOP_DEFINES_SVH
`define IMAGE_DOWNSCALE_2X2_AVERAGE_TOP_DEFINES_SVH

// Assertion helpers. They expect clk_i and rst_ni in the scope of use.

`define IDS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define IDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ids_pkg.sv */
`default_nettype none

package ids_pkg;

  localparam int unsigned PIX_W       = 8;
  localparam int unsigned SUM_W       = 9;
  localparam int unsigned STORE_W     = 3 * SUM_W;
  localparam int unsigned CFG_W       = 13;
  localparam int unsigned SIZE_MIN    = 2;
  localparam int unsigned WIDTH_RESET  = 640;
  localparam int unsigned HEIGHT_RESET = 480;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic pend_load;
    logic store_wr;
    logic store_rd;
    logic last;
  } step_t;

endpackage

`default_nettype wire

/* design/image_downscale_2x2_average_top.sv */
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_stall_o    red_in_i, green_in_i, blue_in_i
// out       output     out_valid_o / out_stall_i  red_out_o, green_out_o, blue_out_o,
//                                                 frame_last_o
// cfg       input      cfg_we_i                   cfg_index_i, cfg_wdata_i
//
// One item is accepted per cycle while the output side takes results.
// A result is registered in the line store read stage, then in the output register.
// Reset clears counters and handshake state and loads the reset sizes;
// the line store is not cleared.
// in_stall_o rises only when the output register is full and stalled and
// the line store read stage already holds a result.

`default_nettype none

`include "image_downscale_2x2_average_top_defines.svh"

module image_downscale_2x2_average_top #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [0:0]                 cfg_index_i,
  input  wire logic [ids_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [ids_pkg::PIX_W-1:0]  red_in_i,
  input  wire logic [ids_pkg::PIX_W-1:0]  green_in_i,
  input  wire logic [ids_pkg::PIX_W-1:0]  blue_in_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic      [ids_pkg::PIX_W-1:0]  red_out_o,
  output logic      [ids_pkg::PIX_W-1:0]  green_out_o,
  output logic      [ids_pkg::PIX_W-1:0]  blue_out_o,
  output logic                            frame_last_o
);

  localparam int unsigned STORE_DEPTH = MAX_WIDTH / 2;
  localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned SW = ids_pkg::SUM_W;

  ids_pkg::step_t              step;
  logic [AW-1:0]               slot;
  logic                        accept, s1_move;
  logic [ids_pkg::STORE_W-1:0] pend_q, pair_sum, upper;
  logic [SW-1:0]               sum_r, sum_g, sum_b;
  logic                        s1_valid_q, s1_last_q;
  logic [ids_pkg::STORE_W-1:0] s1_sum_q;
  logic [SW:0]                 tot_r, tot_g, tot_b;

  assign in_stall_o = s1_valid_q && out_valid_o && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign s1_move    = s1_valid_q && (!out_valid_o || !out_stall_i);

  ids_raster_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AW         (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .step_o      (step),
    .slot_o      (slot)
  );

  assign sum_r    = pend_q[3*SW-1:2*SW] + SW'(red_in_i);
  assign sum_g    = pend_q[2*SW-1:SW]   + SW'(green_in_i);
  assign sum_b    = pend_q[SW-1:0]      + SW'(blue_in_i);
  assign pair_sum = {sum_r, sum_g, sum_b};

  ids_line_store #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (accept && step.store_wr),
    .waddr_i (slot),
    .wdata_i (pair_sum),
    .re_i    (accept && step.store_rd),
    .raddr_i (slot),
    .rdata_o (upper)
  );

  assign tot_r = (SW+1)'(upper[3*SW-1:2*SW]) + (SW+1)'(s1_sum_q[3*SW-1:2*SW]);
  assign tot_g = (SW+1)'(upper[2*SW-1:SW])   + (SW+1)'(s1_sum_q[2*SW-1:SW]);
  assign tot_b = (SW+1)'(upper[SW-1:0])      + (SW+1)'(s1_sum_q[SW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (accept && step.pend_load) begin
        pend_q <= {SW'(red_in_i), SW'(green_in_i), SW'(blue_in_i)};
      end
      if (accept && step.store_rd) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && step.store_rd) begin
      s1_sum_q  <= pair_sum;
      s1_last_q <= step.last;
    end
    if (s1_move) begin
      red_out_o    <= tot_r[SW:2];
      green_out_o  <= tot_g[SW:2];
      blue_out_o   <= tot_b[SW:2];
      frame_last_o <= s1_last_q;
    end
  end

  `IDS_ASSERT_SAME(a_stall, in_stall_o, out_valid_o && out_stall_i && s1_valid_q, "bad stall")
  `IDS_ASSERT_SAME(a_store_port, accept, !(step.store_wr && step.store_rd), "store port clash")
  `IDS_ASSERT_NEXT(a_read_tracked, accept && step.store_rd, s1_valid_q, "read stage missed")

endmodule

`default_nettype wire

/* design/ids_line_store.sv */
`default_nettype none

module ids_line_store #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = 11
) (
  input  wire logic                         clk_i,
  input  wire logic                         we_i,
  input  wire logic [AW-1:0]                waddr_i,
  input  wire logic [ids_pkg::STORE_W-1:0]  wdata_i,
  input  wire logic                         re_i,
  input  wire logic [AW-1:0]                raddr_i,
  output logic      [ids_pkg::STORE_W-1:0]  rdata_o
);

  logic [ids_pkg::STORE_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* design/ids_raster_ctrl.sv */
`default_nettype none

module ids_raster_ctrl #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096,
  parameter int unsigned AW         = 11
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [0:0]                 cfg_index_i,
  input  wire logic [ids_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  wire logic                       accept_i,
  output ids_pkg::step_t                  step_o,
  output logic      [AW-1:0]              slot_o
);

  localparam int unsigned CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RST_W =
    (ids_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : ids_pkg::WIDTH_RESET;
  localparam int unsigned RST_H =
    (ids_pkg::HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : ids_pkg::HEIGHT_RESET;

  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic [WW-1:0] width_q, width_d;
  logic [HW-1:0] height_q, height_d;
  logic [WW-1:0] col_ext, width_even;
  logic [HW-1:0] row_ext, height_even;
  logic          col_end, row_end;

  always_comb begin
    if (cfg_wdata_i < ids_pkg::CFG_W'(ids_pkg::SIZE_MIN)) begin
      width_d = WW'(ids_pkg::SIZE_MIN);
    end else if (32'(cfg_wdata_i) > 32'(MAX_WIDTH)) begin
      width_d = WW'(MAX_WIDTH);
    end else begin
      width_d = WW'(cfg_wdata_i);
    end
    if (cfg_wdata_i < ids_pkg::CFG_W'(ids_pkg::SIZE_MIN)) begin
      height_d = HW'(ids_pkg::SIZE_MIN);
    end else if (32'(cfg_wdata_i) > 32'(MAX_HEIGHT)) begin
      height_d = HW'(MAX_HEIGHT);
    end else begin
      height_d = HW'(cfg_wdata_i);
    end
  end

  assign col_ext     = WW'(col_q);
  assign row_ext     = HW'(row_q);
  assign width_even  = {width_q[WW-1:1], 1'b0};
  assign height_even = {height_q[HW-1:1], 1'b0};
  assign col_end     = (col_ext + WW'(1)) >= width_q;
  assign row_end     = (row_ext + HW'(1)) >= height_q;

  always_comb begin
    step_o = '0;
    if (col_ext < width_even) begin
      step_o.pend_load = ~col_q[0];
      if (col_q[0] && (row_ext < height_even)) begin
        step_o.store_wr = ~row_q[0];
        step_o.store_rd = row_q[0];
      end
    end
    step_o.last = (col_ext == width_even - WW'(1)) && (row_ext == height_even - HW'(1));
  end

  assign slot_o = AW'(col_q >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      width_q  <= WW'(RST_W);
      height_q <= HW'(RST_H);
    end else begin
      if (cfg_we_i) begin
        unique case (ids_pkg::cfg_reg_e'(cfg_index_i))
          ids_pkg::REG_IMAGE_WIDTH:  width_q  <= width_d;
          ids_pkg::REG_IMAGE_HEIGHT: height_q <= height_d;
          default: ;
        endcase
      end
      if (accept_i) begin
        if (col_end) begin
          col_q <= '0;
          row_q <= row_end ? '0 : row_q + RW'(1);
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire
